FILE: src/psgd_pkg.sv
// Shared types and constants for the packet sequence gap detector.
package psgd_pkg;

    localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
    localparam logic [1:0] VERDICT_BAD_TIME = 2'd1;
    localparam logic [1:0] VERDICT_DUPLICATE = 2'd2;

    localparam logic [31:0] TIME_UNTRUSTED = 32'hFFFF_FFFF;
    localparam logic [32:0] TIME_WINDOW = 33'd10;

    localparam logic [15:0] SPP_RESET = 16'd16;
    localparam logic [31:0] SPS_RESET = 32'd195312;

    // Register index on the configuration port (address bit 2).
    localparam logic REG_SPP = 1'b0;
    localparam logic REG_SPS = 1'b1;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic       div_sel_wrap;
        logic       wrap_load;
        logic       commit;
        logic [1:0] verdict;
    } dp_cmd_t;

    typedef struct packed {
        logic bad;
        logic b_lt;
        logic dup;
        logic div_done;
    } dp_sts_t;

endpackage

FILE: src/packet_sequence_gap_detector_top.sv
// Top level: configuration registers, controller and datapath.
//
// One packet header (time_seconds, block_number) is taken per item on the
// input channel, and one result item (verdict, fill_count, lost_total,
// accepted_total) is given on the output channel for every input item.
// Headers are handled one at a time: in_ready is high only while the block
// waits for a header. For an accepted item, the serial divider turns the
// block distance into a packet count; dropped items skip that division,
// and a bad timestamp is dropped at the time check before the distance is
// formed. After reset or a configuration write, the first item whose block
// number lies behind the last one also computes the block wrap on the same
// divider. The result sits in an output register, so the next header is
// taken while it waits; if the receiver stalls, the following result holds
// inside until the register frees. Reset clears the reference, the totals
// and the cached wrap and restores samples_per_packet to 16 and
// samples_per_second to 195312. Configuration must be written over the APB
// port only while the block is idle; the block itself does not enforce
// this.
module packet_sequence_gap_detector_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] time_seconds,
    input  logic [31:0] block_number,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  verdict,
    output logic [31:0] fill_count,
    output logic [47:0] lost_total,
    output logic [47:0] accepted_total
);

    logic [15:0] spp_reg;
    logic [31:0] sps_reg;
    logic        cfg_wr;

    psgd_pkg::dp_cmd_t cmd;
    psgd_pkg::dp_sts_t sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg <= psgd_pkg::SPP_RESET;
            sps_reg <= psgd_pkg::SPS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                psgd_pkg::REG_SPP: spp_reg <= pwdata[15:0];
                psgd_pkg::REG_SPS: sps_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            psgd_pkg::REG_SPP: prdata = {16'd0, spp_reg};
            psgd_pkg::REG_SPS: prdata = sps_reg;
            default: prdata = 32'd0;
        endcase
    end

    psgd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .cfg_wr    (cfg_wr),
        .sts       (sts),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    psgd_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .time_seconds   (time_seconds),
        .block_number   (block_number),
        .spp            (spp_reg),
        .sps            (sps_reg),
        .sts            (sts),
        .verdict        (verdict),
        .fill_count     (fill_count),
        .lost_total     (lost_total),
        .accepted_total (accepted_total)
    );

endmodule

FILE: src/psgd_div.sv
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
module psgd_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] dq_reg;
    logic [15:0] rem_reg;
    logic [15:0] dvs_reg;

    logic [16:0] rem_shift;
    logic [16:0] rem_sub;
    logic        ge;

    assign rem_shift = {rem_reg, dq_reg[31]};
    assign ge = rem_shift >= {1'b0, dvs_reg};
    assign rem_sub = rem_shift - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 5'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg <= 5'd31;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg <= dividend;
            rem_reg <= 16'd0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so 16 bits hold it.
            dq_reg <= {dq_reg[30:0], ge};
            rem_reg <= ge ? rem_sub[15:0] : rem_shift[15:0];
        end
    end

    assign done = done_reg;
    assign quotient = dq_reg;

endmodule

FILE: src/psgd_dp.sv
// Datapath: header registers, reference state, block distance, divider and totals.
module psgd_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  psgd_pkg::dp_cmd_t cmd,
    input  logic [31:0]       time_seconds,
    input  logic [31:0]       block_number,
    input  logic [15:0]       spp,
    input  logic [31:0]       sps,
    output psgd_pkg::dp_sts_t sts,
    output logic [1:0]        verdict,
    output logic [31:0]       fill_count,
    output logic [47:0]       lost_total,
    output logic [47:0]       accepted_total
);

    logic [31:0] time_reg;
    logic [31:0] block_reg;
    logic [31:0] last_time_reg;
    logic [31:0] last_block_reg;
    logic [31:0] start_time_reg;
    logic        any_accepted_reg;
    logic [47:0] lost_reg;
    logic [47:0] accepted_reg;
    logic [31:0] wrap_reg;
    logic [1:0]  verdict_reg;
    logic [31:0] fill_reg;

    logic [15:0] spp_eff;
    logic [31:0] diff;
    logic [31:0] fill;
    logic        capture;
    logic        accept;
    logic        div_done;
    logic [31:0] quotient;

    assign spp_eff = (spp == 16'd0) ? 16'd1 : spp;
    assign capture = !any_accepted_reg && (start_time_reg == 32'd0);
    assign accept = cmd.commit && (cmd.verdict == psgd_pkg::VERDICT_ACCEPT);

    assign sts.bad = (time_reg == psgd_pkg::TIME_UNTRUSTED)
                  || (({1'b0, last_time_reg} + psgd_pkg::TIME_WINDOW) < {1'b0, time_reg});
    assign sts.b_lt = block_reg < last_block_reg;
    // Behind the last block the distance wraps around the blocks of one second.
    assign diff = block_reg - last_block_reg + (sts.b_lt ? wrap_reg : 32'd0);
    assign sts.dup = diff < {16'd0, spp_eff};
    assign sts.div_done = div_done;
    assign fill = quotient - 32'd1;

    psgd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (cmd.div_sel_wrap ? sps : diff),
        .divisor  (spp_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= 32'd0;
            last_block_reg <= 32'd0;
            start_time_reg <= 32'd0;
            any_accepted_reg <= 1'b0;
            lost_reg <= 48'd0;
            accepted_reg <= 48'd0;
        end
        else if (cmd.load)
        begin
            // Until a packet is accepted, a header with a nonzero time sets the reference.
            if (capture)
            begin
                start_time_reg <= time_seconds;
                last_time_reg <= time_seconds;
                if (last_block_reg == 32'd0)
                begin
                    last_block_reg <= block_number;
                end
            end
        end
        else if (accept)
        begin
            lost_reg <= lost_reg + {16'd0, fill};
            accepted_reg <= accepted_reg + 48'd1;
            last_time_reg <= time_reg;
            last_block_reg <= block_reg;
            any_accepted_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            time_reg <= time_seconds;
            block_reg <= block_number;
        end
        if (cmd.wrap_load)
        begin
            wrap_reg <= quotient;
        end
        if (cmd.commit)
        begin
            verdict_reg <= cmd.verdict;
            fill_reg <= accept ? fill : 32'd0;
        end
    end

    assign verdict = verdict_reg;
    assign fill_count = fill_reg;
    assign lost_total = lost_reg;
    assign accepted_total = accepted_reg;

endmodule

FILE: src/psgd_ctrl.sv
// Controller: sequences check, divisions and commit of one item at a time.
module psgd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_ready,
    input  logic              cfg_wr,
    input  psgd_pkg::dp_sts_t sts,
    output logic              in_ready,
    output logic              out_valid,
    output psgd_pkg::dp_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_WRAP   = 6'b000100,
        S_DIFF   = 6'b001000,
        S_DIV    = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] verdict_reg;
    logic [1:0] verdict_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       wrap_valid_reg;
    logic       wrap_valid_next;

    always_comb
    begin
        state_next = state_reg;
        verdict_next = verdict_reg;
        wrap_valid_next = wrap_valid_reg;
        cmd = '0;
        cmd.verdict = verdict_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.bad)
                begin
                    verdict_next = psgd_pkg::VERDICT_BAD_TIME;
                    state_next = S_FINISH;
                end
                else if (sts.b_lt && !wrap_valid_reg)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel_wrap = 1'b1;
                    state_next = S_WRAP;
                end
                else
                begin
                    state_next = S_DIFF;
                end
            end
            S_WRAP:
            begin
                if (sts.div_done)
                begin
                    cmd.wrap_load = 1'b1;
                    wrap_valid_next = 1'b1;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                if (sts.dup)
                begin
                    verdict_next = psgd_pkg::VERDICT_DUPLICATE;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    verdict_next = psgd_pkg::VERDICT_ACCEPT;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // A new divisor or rate makes the cached block wrap stale.
        if (cfg_wr)
        begin
            wrap_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            verdict_reg <= psgd_pkg::VERDICT_ACCEPT;
            out_valid_reg <= 1'b0;
            wrap_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            verdict_reg <= verdict_next;
            out_valid_reg <= out_valid_next;
            wrap_valid_reg <= wrap_valid_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: src/psgd_checker.sv
// Port-level checks for the packet sequence gap detector, bound to the top level.
module psgd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  verdict,
    input logic [31:0] fill_count,
    input logic [47:0] lost_total,
    input logic [47:0] accepted_total
);

    // A result that is not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(fill_count)
            && $stable(lost_total) && $stable(accepted_total))
    else $error("stalled result changed");

    // Only the three defined verdicts appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> verdict == psgd_pkg::VERDICT_ACCEPT
            || verdict == psgd_pkg::VERDICT_BAD_TIME
            || verdict == psgd_pkg::VERDICT_DUPLICATE)
    else $error("undefined verdict");

    // Dropped items never ask for fill packets.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict != psgd_pkg::VERDICT_ACCEPT |-> fill_count == 32'd0)
    else $error("fill on a dropped item");

    // Items are handled one at a time, so an accepted header closes the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input open while an item is in work");

endmodule

bind packet_sequence_gap_detector_top psgd_checker u_checker (.*);
